// ===== hw/rtl/spq_pkg.sv =====
// Shared types and constants for the sorted priority queue.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package spq_pkg;

	// Default sizing, used as the defaults of the top level parameters.
	localparam int CAPACITY_DEF = 16;
	localparam int ID_BITS_DEF  = 16;

	// Fixed field widths.
	localparam int OP_BITS     = 3;
	localparam int PRIO_BITS   = 7;
	localparam int STATUS_BITS = 2;

	// Operation codes carried in the request word.
	localparam logic [OP_BITS-1:0] OP_INSERT = 3'd0;
	localparam logic [OP_BITS-1:0] OP_POP    = 3'd1;
	localparam logic [OP_BITS-1:0] OP_PEEK   = 3'd2;
	localparam logic [OP_BITS-1:0] OP_CHANGE = 3'd3;
	localparam logic [OP_BITS-1:0] OP_FIND   = 3'd4;

	// Status codes carried in the response word.
	localparam logic [STATUS_BITS-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_BITS-1:0] STAT_EMPTY    = 2'd1;
	localparam logic [STATUS_BITS-1:0] STAT_FULL     = 2'd2;
	localparam logic [STATUS_BITS-1:0] STAT_NOTFOUND = 2'd3;

	// Command broadcast to every cell of the chain.
	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_POP,
		CMD_REMOVE
	} spq_cmd_t;

	// Control group broadcast from the sequencer to the cells.
	typedef struct packed {
		spq_cmd_t             cmd;
		logic [PRIO_BITS-1:0] prio;
	} spq_ctl_t;

endpackage

// ===== hw/rtl/spq_ifs.sv =====
// Valid/ready channel interfaces for the request and response words.
// Depends on spq_pkg for field widths.
`timescale 1ns / 1ps

interface spq_req_if
	import spq_pkg::*;
#(
	parameter int ID_BITS = ID_BITS_DEF
) ();
	logic                 valid;
	logic                 ready;
	logic [OP_BITS-1:0]   opcode;
	logic [ID_BITS-1:0]   item_id;
	logic [PRIO_BITS-1:0] priority_req;

	modport source (output valid, opcode, item_id, priority_req, input ready);
	modport sink   (input valid, opcode, item_id, priority_req, output ready);
endinterface

interface spq_rsp_if
	import spq_pkg::*;
#(
	parameter int ID_BITS  = ID_BITS_DEF,
	parameter int CNT_BITS = $clog2(CAPACITY_DEF + 1)
) ();
	logic                   valid;
	logic                   ready;
	logic [ID_BITS-1:0]     result_id;
	logic [PRIO_BITS-1:0]   result_priority;
	logic [STATUS_BITS-1:0] status;
	logic [CNT_BITS-1:0]    entry_count;

	modport source (output valid, result_id, result_priority, status, entry_count,
		input ready);
	modport sink   (input valid, result_id, result_priority, status, entry_count,
		output ready);
endinterface

// ===== hw/rtl/spq_cell.sv =====
// One slot of the sorted chain: holds an id and a priority and trades them
// with its neighbors under the broadcast command. Depends on spq_pkg.
`timescale 1ns / 1ps

module spq_cell
	import spq_pkg::*;
#(
	parameter int IDX      = 0,
	parameter int ID_BITS  = ID_BITS_DEF,
	parameter int CNT_BITS = $clog2(CAPACITY_DEF + 1)
) (
	input  logic                 clk,
	input  spq_ctl_t             ctl,
	input  logic [ID_BITS-1:0]   key_id,
	input  logic [CNT_BITS-1:0]  count,
	// Neighbor toward the head.
	input  logic [ID_BITS-1:0]   left_id,
	input  logic [PRIO_BITS-1:0] left_prio,
	input  logic                 left_ge,
	input  logic                 pre_hit_in,
	// Neighbor toward the tail.
	input  logic [ID_BITS-1:0]   right_id,
	input  logic [PRIO_BITS-1:0] right_prio,
	input  logic                 right_match,
	// Own state and flags.
	output logic [ID_BITS-1:0]   cur_id,
	output logic [PRIO_BITS-1:0] cur_prio,
	output logic                 ge,
	output logic                 match,
	output logic                 pre_hit_out,
	output logic [ID_BITS-1:0]   sel_id,
	output logic [PRIO_BITS-1:0] sel_prio
);

	localparam logic [CNT_BITS-1:0] IDX_C = CNT_BITS'(IDX);

	logic [ID_BITS-1:0]   id_q;
	logic [PRIO_BITS-1:0] prio_q;
	logic                 occupied;
	logic                 last_match;

	// Compare flags; only slots below the fill count take part.
	assign occupied    = IDX_C < count;
	assign ge          = occupied && (ctl.prio < prio_q);
	assign match       = occupied && (prio_q == ctl.prio);
	assign pre_hit_out = pre_hit_in || (occupied && (id_q == key_id));
	assign last_match  = match && !right_match;

	assign cur_id   = id_q;
	assign cur_prio = prio_q;
	assign sel_id   = last_match ? id_q : '0;
	assign sel_prio = last_match ? prio_q : '0;

	// Slot update: keep, take the new word, or shift from a neighbor.
	always_ff @(posedge clk) begin
		case (ctl.cmd)
			CMD_INSERT: begin
				if (!ge) begin
					if (left_ge) begin
						id_q   <= key_id;
						prio_q <= ctl.prio;
					end else begin
						id_q   <= left_id;
						prio_q <= left_prio;
					end
				end
			end
			CMD_POP: begin
				id_q   <= right_id;
				prio_q <= right_prio;
			end
			CMD_REMOVE: begin
				if (pre_hit_out) begin
					id_q   <= right_id;
					prio_q <= right_prio;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: sequencer plus a chain of slots.
// Depends on spq_pkg, spq_ifs and spq_cell.
//
//   channel | dir | word fields
//   --------+-----+---------------------------------------------------
//   req     | in  | opcode, item_id, priority_req
//   rsp     | out | result_id, result_priority, status, entry_count
//
// Every operation is accepted, then makes one pass over the slot chain; a
// successful priority change makes two, a remove and then a re-insert.
// Reset clears the state, the fill count and the response valid flag;
// slot contents are not reset and are read only below the fill count.
// A response waiting in the output register does not block the next
// accept; the chain holds its pass until the output register is free.
`timescale 1ns / 1ps

module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int ID_BITS  = ID_BITS_DEF,
	parameter int CNT_BITS = $clog2(CAPACITY + 1)
) (
	input  logic     clk,
	input  logic     arst_n,
	spq_req_if.sink  req,
	spq_rsp_if.source rsp
);

	localparam logic [CNT_BITS-1:0] FULL_C = CNT_BITS'(CAPACITY);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_REINS
	} state_t;

	state_t               state_q;
	logic [OP_BITS-1:0]   op_q;
	logic [ID_BITS-1:0]   id_q;
	logic [PRIO_BITS-1:0] prio_q;
	logic [CNT_BITS-1:0]  count_q;

	logic                   rsp_valid_q;
	logic [ID_BITS-1:0]     rsp_id_q;
	logic [PRIO_BITS-1:0]   rsp_prio_q;
	logic [STATUS_BITS-1:0] rsp_status_q;
	logic [CNT_BITS-1:0]    rsp_count_q;

	// Chain wiring.
	logic [ID_BITS-1:0]   cell_id   [CAPACITY];
	logic [PRIO_BITS-1:0] cell_prio [CAPACITY];
	logic                 cell_ge   [CAPACITY];
	logic                 cell_match[CAPACITY];
	logic                 cell_pre  [CAPACITY];
	logic [ID_BITS-1:0]   sel_id    [CAPACITY];
	logic [PRIO_BITS-1:0] sel_prio  [CAPACITY];

	spq_ctl_t             ctl;
	logic                 out_free;
	logic                 advance;
	logic                 wr_res;
	logic [ID_BITS-1:0]   res_id;
	logic [PRIO_BITS-1:0] res_prio;
	logic [STATUS_BITS-1:0] res_status;
	logic [CNT_BITS-1:0]  count_d;
	state_t               state_d;
	logic [ID_BITS-1:0]   find_id;
	logic [PRIO_BITS-1:0] find_prio;
	logic                 find_hit;

	assign req.ready = (state_q == S_IDLE);
	assign out_free  = !rsp_valid_q || rsp.ready;

	// Slot chain: each cell sees its two neighbors and the broadcast.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ID_BITS-1:0]   l_id, r_id;
		logic [PRIO_BITS-1:0] l_prio, r_prio;
		logic                 l_ge, l_pre, r_match;

		if (i == 0) begin : g_head
			assign l_id   = '0;
			assign l_prio = '0;
			assign l_ge   = 1'b1;
			assign l_pre  = 1'b0;
		end else begin : g_mid_l
			assign l_id   = cell_id[i-1];
			assign l_prio = cell_prio[i-1];
			assign l_ge   = cell_ge[i-1];
			assign l_pre  = cell_pre[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign r_id    = '0;
			assign r_prio  = '0;
			assign r_match = 1'b0;
		end else begin : g_mid_r
			assign r_id    = cell_id[i+1];
			assign r_prio  = cell_prio[i+1];
			assign r_match = cell_match[i+1];
		end

		spq_cell #(
			.IDX      (i),
			.ID_BITS  (ID_BITS),
			.CNT_BITS (CNT_BITS)
		) u_cell (
			.clk         (clk),
			.ctl         (ctl),
			.key_id      (id_q),
			.count       (count_q),
			.left_id     (l_id),
			.left_prio   (l_prio),
			.left_ge     (l_ge),
			.pre_hit_in  (l_pre),
			.right_id    (r_id),
			.right_prio  (r_prio),
			.right_match (r_match),
			.cur_id      (cell_id[i]),
			.cur_prio    (cell_prio[i]),
			.ge          (cell_ge[i]),
			.match       (cell_match[i]),
			.pre_hit_out (cell_pre[i]),
			.sel_id      (sel_id[i]),
			.sel_prio    (sel_prio[i])
		);
	end

	// Gather the last priority match; at most one cell drives nonzero.
	always_comb begin
		find_id   = '0;
		find_prio = '0;
		find_hit  = 1'b0;
		for (int i = 0; i < CAPACITY; i++) begin
			find_id   = find_id | sel_id[i];
			find_prio = find_prio | sel_prio[i];
			find_hit  = find_hit | cell_match[i];
		end
	end

	// Sequencer: choose the chain command and the response word.
	always_comb begin
		ctl.cmd    = CMD_HOLD;
		ctl.prio   = prio_q;
		advance    = 1'b0;
		wr_res     = 1'b0;
		res_id     = '0;
		res_prio   = '0;
		res_status = STAT_OK;
		count_d    = count_q;
		state_d    = state_q;
		case (state_q)
			S_IDLE: begin
				if (req.valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				advance = out_free;
				wr_res  = 1'b1;
				state_d = S_IDLE;
				case (op_q)
					OP_INSERT: begin
						if (count_q == FULL_C) begin
							res_status = STAT_FULL;
						end else begin
							ctl.cmd = CMD_INSERT;
							count_d = count_q + 1'b1;
						end
					end
					OP_POP, OP_PEEK: begin
						if (count_q == '0) begin
							res_status = STAT_EMPTY;
						end else begin
							res_id   = cell_id[0];
							res_prio = cell_prio[0];
							if (op_q == OP_POP) begin
								ctl.cmd = CMD_POP;
								count_d = count_q - 1'b1;
							end
						end
					end
					OP_CHANGE: begin
						if (cell_pre[CAPACITY-1]) begin
							// Remove now, re-insert on the next pass.
							advance = 1'b1;
							wr_res  = 1'b0;
							ctl.cmd = CMD_REMOVE;
							count_d = count_q - 1'b1;
							state_d = S_REINS;
						end else begin
							res_status = STAT_NOTFOUND;
						end
					end
					OP_FIND: begin
						if (find_hit) begin
							res_id   = find_id;
							res_prio = find_prio;
						end else begin
							res_status = STAT_NOTFOUND;
						end
					end
					default: begin
					end
				endcase
			end
			S_REINS: begin
				advance = out_free;
				wr_res  = 1'b1;
				ctl.cmd = CMD_INSERT;
				count_d = count_q + 1'b1;
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// A pass that cannot deliver its word waits and changes nothing.
		if (state_q != S_IDLE && !advance) begin
			ctl.cmd = CMD_HOLD;
			count_d = count_q;
			state_d = state_q;
			wr_res  = 1'b0;
		end
	end

	// Control state and the fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (wr_res) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Request capture and response payload.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			op_q   <= req.opcode;
			id_q   <= req.item_id;
			prio_q <= req.priority_req;
		end
		if (wr_res) begin
			rsp_id_q     <= res_id;
			rsp_prio_q   <= res_prio;
			rsp_status_q <= res_status;
			rsp_count_q  <= count_d;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.result_id       = rsp_id_q;
	assign rsp.result_priority = rsp_prio_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.entry_count     = rsp_count_q;

endmodule

// ===== hw/rtl/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg and on the top level's port names.
`timescale 1ns / 1ps

module spq_checker
	import spq_pkg::*;
#(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int ID_BITS  = ID_BITS_DEF,
	parameter int CNT_BITS = $clog2(CAPACITY + 1)
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   rsp_valid,
	input logic                   rsp_ready,
	input logic [ID_BITS-1:0]     rsp_id,
	input logic [PRIO_BITS-1:0]   rsp_prio,
	input logic [STATUS_BITS-1:0] rsp_status,
	input logic [CNT_BITS-1:0]    rsp_count
);

	// The fill count never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_count <= CNT_BITS'(CAPACITY))
		else $error("entry_count above capacity");

	// A refused insert reports a full queue.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_FULL |-> rsp_count == CNT_BITS'(CAPACITY))
		else $error("full status with room left");

	// An empty report carries an empty queue and no entry.
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == STAT_EMPTY
		|-> rsp_count == '0 && rsp_id == '0 && rsp_prio == '0)
		else $error("empty status with entries or data");

	// A stalled response word stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

endmodule

bind sorted_priority_queue spq_checker #(
	.CAPACITY (CAPACITY),
	.ID_BITS  (ID_BITS),
	.CNT_BITS (CNT_BITS)
) u_spq_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_id     (rsp.result_id),
	.rsp_prio   (rsp.result_priority),
	.rsp_status (rsp.status),
	.rsp_count  (rsp.entry_count)
);

// ===== tb/sorted_priority_queue_tb.sv =====
// Self-checking testbench for sorted_priority_queue: directed and random words
// on the request channel, with every response checked against a local queue model.
// Depends on spq_pkg, the spq_req_if/spq_rsp_if interfaces and the block's RTL.
`timescale 1ns / 1ps

module sorted_priority_queue_tb;
	import spq_pkg::*;

	localparam int CNT_BITS = $clog2(CAPACITY_DEF + 1);
	localparam logic [OP_BITS-1:0] OP_SPARE_FIRST = 3'd5;
	localparam logic [OP_BITS-1:0] OP_SPARE_LAST  = 3'd7;

	typedef struct {
		logic [ID_BITS_DEF-1:0] id;
		logic [PRIO_BITS-1:0]   prio;
	} held_entry_t;

	typedef struct {
		logic [ID_BITS_DEF-1:0] id;
		logic [PRIO_BITS-1:0]   prio;
		logic [STATUS_BITS-1:0] status;
		logic [CNT_BITS-1:0]    count;
	} reply_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	spq_req_if req_ch ();
	spq_rsp_if rsp_ch ();

	sorted_priority_queue i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Model of the queue contents, head at index 0, and the replies still owed.
	held_entry_t held_entries[$];
	reply_t      awaited_replies[$];

	int mismatch_count   = 0;
	bit send_idle_on     = 1'b0;
	bit recv_idle_on     = 1'b0;
	int rsp_hold_cycles  = 0;

	logic [PRIO_BITS-1:0] prio_choices[6] = '{7'd0, 7'd20, 7'd50, 7'd99, 7'd100, 7'd127};

	always #5 clk = ~clk;

	// Applies one operation to the model and returns the reply it must produce.
	function automatic reply_t apply_queue_op(input logic [OP_BITS-1:0] op,
		input logic [ID_BITS_DEF-1:0] id, input logic [PRIO_BITS-1:0] prio);
		reply_t      r;
		held_entry_t e;
		int          pos;
		int          hit;
		r = '{id: '0, prio: '0, status: STAT_OK, count: '0};
		e = '{id: id, prio: prio};
		hit = -1;
		case (op)
			OP_INSERT: begin
				if (held_entries.size() >= CAPACITY_DEF) begin
					r.status = STAT_FULL;
				end else begin
					pos = 0;
					while (pos < held_entries.size() && prio < held_entries[pos].prio)
						pos++;
					held_entries.insert(pos, e);
				end
			end
			OP_POP, OP_PEEK: begin
				if (held_entries.size() == 0) begin
					r.status = STAT_EMPTY;
				end else begin
					r.id   = held_entries[0].id;
					r.prio = held_entries[0].prio;
					if (op == OP_POP)
						held_entries.delete(0);
				end
			end
			OP_CHANGE: begin
				// The entry nearest the head wins when an id is held twice.
				for (int k = 0; k < held_entries.size(); k++)
					if (hit < 0 && held_entries[k].id == id)
						hit = k;
				if (hit < 0) begin
					r.status = STAT_NOTFOUND;
				end else begin
					held_entries.delete(hit);
					pos = 0;
					while (pos < held_entries.size() && prio < held_entries[pos].prio)
						pos++;
					held_entries.insert(pos, e);
				end
			end
			OP_FIND: begin
				// The last match in queue order is reported.
				for (int k = 0; k < held_entries.size(); k++)
					if (held_entries[k].prio == prio)
						hit = k;
				if (hit < 0) begin
					r.status = STAT_NOTFOUND;
				end else begin
					r.id   = held_entries[hit].id;
					r.prio = held_entries[hit].prio;
				end
			end
			default: ;
		endcase
		r.count = CNT_BITS'(held_entries.size());
		return r;
	endfunction

	function automatic int draw_gap(input bit idle_on);
		return idle_on ? $urandom_range(0, 10) : 0;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// Offers one request word and records the reply owed once it is accepted.
	task automatic send_word(input logic [OP_BITS-1:0] op,
		input logic [ID_BITS_DEF-1:0] id, input logic [PRIO_BITS-1:0] prio);
		int gap;
		gap = draw_gap(send_idle_on);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.opcode       <= op;
		req_ch.item_id      <= id;
		req_ch.priority_req <= prio;
		do @(posedge clk); while (!req_ch.ready);
		awaited_replies.push_back(apply_queue_op(op, id, prio));
	endtask

	// Draws one random word; fill_bias minus the spare share is the percent of inserts.
	task automatic send_random_word(input int fill_bias);
		logic [OP_BITS-1:0]     op;
		logic [ID_BITS_DEF-1:0] id;
		logic [PRIO_BITS-1:0]   prio;
		int                     r;
		r = $urandom_range(0, 99);
		if (r < 3)
			op = OP_BITS'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
		else if (r < fill_bias)
			op = OP_INSERT;
		else
			case ($urandom_range(0, 3))
				0: op = OP_POP;
				1: op = OP_PEEK;
				2: op = OP_CHANGE;
				default: op = OP_FIND;
			endcase
		// A small id pool gives duplicates; full-width ids exercise every bit.
		id = ($urandom_range(0, 3) == 0) ? ID_BITS_DEF'($urandom)
			: ID_BITS_DEF'($urandom_range(0, 19));
		prio = ($urandom_range(0, 2) == 0) ? PRIO_BITS'($urandom)
			: prio_choices[$urandom_range(0, 5)];
		// Mostly aim changes and finds at entries that are actually held.
		if (held_entries.size() > 0 && $urandom_range(0, 3) != 0) begin
			r = $urandom_range(0, held_entries.size() - 1);
			if (op == OP_CHANGE)
				id = held_entries[r].id;
			else if (op == OP_FIND)
				prio = held_entries[r].prio;
		end
		send_word(op, id, prio);
	endtask

	// Every operation but insert on an empty queue, plus a spare opcode.
	task automatic test_empty_queue();
		send_word(OP_POP, 16'h1234, 7'd10);
		send_word(OP_PEEK, 16'h0000, 7'd0);
		send_word(OP_CHANGE, 16'h0005, 7'd3);
		send_word(OP_FIND, 16'h0000, 7'd0);
		send_word(OP_SPARE_FIRST, 16'hFFFF, 7'd127);
	endtask

	// Ordering, ties, priorities above 100, duplicate ids and last-match find.
	task automatic test_ordering();
		send_word(OP_INSERT, 16'h0000, 7'd0);
		send_word(OP_INSERT, 16'hFFFF, 7'd127);
		send_word(OP_INSERT, 16'h0001, 7'd100);
		send_word(OP_INSERT, 16'h0002, 7'd101);
		send_word(OP_INSERT, 16'h0003, 7'd100);
		send_word(OP_INSERT, 16'h0003, 7'd50);
		send_word(OP_FIND, 16'h0000, 7'd100);
		send_word(OP_CHANGE, 16'h0003, 7'd0);
		send_word(OP_PEEK, 16'h0000, 7'd0);
		send_word(OP_FIND, 16'h0000, 7'd99);
		send_word(OP_SPARE_LAST, 16'hAAAA, 7'd55);
		send_word(OP_POP, 16'h0000, 7'd0);
	endtask

	// Fill to capacity, then one insert that must be refused.
	task automatic test_full_queue();
		while (held_entries.size() < CAPACITY_DEF)
			send_word(OP_INSERT, ID_BITS_DEF'($urandom), PRIO_BITS'($urandom));
		send_word(OP_INSERT, 16'h5555, 7'd64);
	endtask

	// Random traffic in stretches with different insert bias and idling.
	task automatic test_random_traffic(input int n_items);
		int fill_bias;
		fill_bias = 50;
		for (int i = 0; i < n_items; i++) begin
			if (i % 50 == 0) begin
				send_idle_on = $urandom_range(0, 3) != 0;
				recv_idle_on = $urandom_range(0, 3) != 0;
				fill_bias    = $urandom_range(15, 85);
			end
			send_random_word(fill_bias);
		end
	endtask

	// The receiver stops for a long stretch while words keep coming.
	task automatic test_backpressure(input int n_items);
		send_idle_on = 1'b0;
		recv_idle_on = 1'b0;
		rsp_hold_cycles = 200;
		for (int i = 0; i < n_items; i++)
			send_random_word(60);
	endtask

	// Response side: random stalls, plus the long hold when one is requested.
	initial begin : rsp_drain
		int gap;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (rsp_hold_cycles > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (rsp_hold_cycles) @(posedge clk);
				rsp_hold_cycles = 0;
			end
			gap = draw_gap(recv_idle_on);
			if (gap > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
		end
	end

	// Compare each accepted response word with the oldest reply owed.
	always @(posedge clk) begin : reply_check
		reply_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (awaited_replies.size() == 0) begin
				report_mismatch("response word with no request outstanding");
			end else begin
				want = awaited_replies.pop_front();
				if (rsp_ch.result_id !== want.id)
					report_mismatch($sformatf("result_id %h, wanted %h",
						rsp_ch.result_id, want.id));
				if (rsp_ch.result_priority !== want.prio)
					report_mismatch($sformatf("result_priority %0d, wanted %0d",
						rsp_ch.result_priority, want.prio));
				if (rsp_ch.status !== want.status)
					report_mismatch($sformatf("status %0d, wanted %0d",
						rsp_ch.status, want.status));
				if (rsp_ch.entry_count !== want.count)
					report_mismatch($sformatf("entry_count %0d, wanted %0d",
						rsp_ch.entry_count, want.count));
			end
		end
	end

	// Main sequence: reset, tests in turn, drain, verdict.
	initial begin
		req_ch.valid        <= 1'b0;
		req_ch.opcode       <= OP_PEEK;
		req_ch.item_id      <= '0;
		req_ch.priority_req <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_queue();
		test_ordering();
		test_full_queue();
		test_random_traffic(1500);
		test_backpressure(60);
		test_random_traffic(60);

		req_ch.valid <= 1'b0;
		while (awaited_replies.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Hang guard, far beyond the slowest correct run.
	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
